[sv/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define QET_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qet assertion failed");

// Checked on every edge, reset included.
`define QET_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qet assertion failed");

`endif

[sv/qet_pkg.sv]
package qet_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 120;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_W = 32;

    localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PPR       = 3'd0,
        REG_TICK_RATE = 3'd1,
        REG_SWAP      = 3'd2,
        REG_REST      = 3'd3,
        REG_STEP_BUF  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] capture_time;
        logic        pin_b;
        logic        pin_a;
    } in_item_t;

    typedef struct packed {
        logic               speed_overflow;
        logic [23:0]        speed_hz_q8;
        logic [15:0]        edge_period;
        logic [17:0]        linear_count;
        logic [17:0]        angle_count;
        logic signed [7:0]  step_buffer;
        logic signed [31:0] step_total;
        logic               step_done;
        logic [1:0]         direction;
    } out_item_t;

endpackage

[sv/qet_div.sv]
module qet_div
    import qet_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             sub_ok;
    logic [DIV_W-1:0] rem_next;

    // one restoring step per cycle while busy, quotient bits shift in behind the dividend
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = shifted - {1'b0, divisor};
        sub_ok   = shifted >= {1'b0, divisor};
        rem_next = sub_ok ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], sub_ok};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/quadrature_encoder_tracker.sv]
// After acceptance an item passes through ST_MUL, ST_START, ST_DIV (the 32-step
// radix-2 speed divider) and ST_OUT; only one item is in flight at a time.
// s_axis_tready is low from acceptance until the result register loads.
// rst_n (async, active low) clears position, step and capture state and
// restores register defaults: ppr 24, tick rate 1600, step buffer value 1.
module quadrature_encoder_tracker
    import qet_pkg::*;
#(
    parameter int STEP_COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_W-1:0]        s_axis_tdata,   // pin_a, pin_b, capture_time[15:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // direction[1:0], step_done,
                                                   // step_total[31:0], step_buffer[7:0],
                                                   // angle_count[17:0], linear_count[17:0],
                                                   // edge_period[15:0], speed_hz_q8[23:0],
                                                   // speed_overflow
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] ppr_reg;
    logic [23:0] tick_reg;
    logic        swap_reg;
    logic [1:0]  rest_reg;
    logic [6:0]  sbv_reg;

    logic [1:0]                  prev_pins_reg;
    dir_t                        last_dir_reg;
    logic [7:0]                  run_reg;
    logic [STEP_COUNT_WIDTH-1:0] step_cnt_reg;
    logic [7:0]                  step_buf_reg;
    logic [17:0]                 angle_reg;
    logic [17:0]                 linear_reg;
    logic [15:0]                 prev_cap_reg;
    logic [15:0]                 period_reg;
    dir_t                        dir_reg;
    logic                        done_reg;
    logic [DIV_W-1:0]            den_reg;
    out_item_t                   out_reg;
    logic                        m_valid_reg;

    in_item_t  in_item;
    logic      accept;
    logic      pin_a_n;
    logic      pin_b_n;
    logic [1:0] pins;
    dir_t      dir;
    logic [17:0] span;
    logic [18:0] angle_inc;
    logic [17:0] lin_clamped;
    logic [7:0]  run_next;
    logic        step_done;
    logic [17:0] angle_next;
    logic [17:0] linear_next;
    logic        div_done;
    logic [DIV_W-1:0] div_q;
    logic        out_free;
    out_item_t   out_next;

    function automatic logic [1:0] next_cw(input logic [1:0] p);
        logic [1:0] r;
        case (p)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd3;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] next_ccw(input logic [1:0] p);
        logic [1:0] r;
        case (p)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd0;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    assign in_item       = in_item_t'(s_axis_tdata);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        pin_a_n = ~in_item.pin_a;
        pin_b_n = ~in_item.pin_b;
        pins    = swap_reg ? {pin_a_n, pin_b_n} : {pin_b_n, pin_a_n};

        if (next_cw(prev_pins_reg) == pins)
            dir = DIR_CW;
        else if (next_ccw(prev_pins_reg) == pins)
            dir = DIR_CCW;
        else
            dir = DIR_NONE;

        if (dir == last_dir_reg)
            run_next = (run_reg == 8'hFF) ? run_reg : run_reg + 8'd1;
        else
            run_next = 8'd0;

        step_done = (dir != DIR_NONE) && (pins == rest_reg) && (run_next >= 8'd3);

        span        = {ppr_reg, 2'b00};
        angle_inc   = {1'b0, angle_reg} + 19'd1;
        lin_clamped = (linear_reg > span) ? span : linear_reg;
        angle_next  = angle_reg;
        linear_next = linear_reg;
        if (span == 18'd0)
        begin
            angle_next  = 18'd0;
            linear_next = 18'd0;
        end
        else if (dir == DIR_CW)
        begin
            angle_next  = (angle_inc >= {1'b0, span}) ? 18'd0 : angle_inc[17:0];
            linear_next = (linear_reg >= span) ? span : linear_reg + 18'd1;
        end
        else if (dir == DIR_CCW)
        begin
            angle_next  = (angle_reg == 18'd0 || angle_reg >= span) ? span - 18'd1
                                                                  : angle_reg - 18'd1;
            linear_next = (lin_clamped != 18'd0) ? lin_clamped - 18'd1 : lin_clamped;
        end
    end

    qet_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .dividend ({tick_reg, 8'h00}),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        out_next.direction    = dir_reg;
        out_next.step_done    = done_reg;
        out_next.step_total   = 32'($signed(step_cnt_reg));
        out_next.step_buffer  = step_buf_reg;
        out_next.angle_count  = angle_reg;
        out_next.linear_count = linear_reg;
        out_next.edge_period  = period_reg;
        if (den_reg == '0 || div_q[DIV_W-1:24] != '0)
        begin
            out_next.speed_hz_q8    = SPEED_MAX;
            out_next.speed_overflow = 1'b1;
        end
        else
        begin
            out_next.speed_hz_q8    = div_q[23:0];
            out_next.speed_overflow = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg  <= 16'd24;
            tick_reg <= 24'd1600;
            swap_reg <= 1'b0;
            rest_reg <= 2'd0;
            sbv_reg  <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PPR:       ppr_reg  <= cfg_data[15:0];
                REG_TICK_RATE: tick_reg <= cfg_data[23:0];
                REG_SWAP:      swap_reg <= cfg_data[0];
                REG_REST:      rest_reg <= cfg_data[1:0];
                REG_STEP_BUF:  sbv_reg  <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            prev_pins_reg <= 2'd0;
            last_dir_reg  <= DIR_NONE;
            run_reg       <= 8'd0;
            step_cnt_reg  <= '0;
            step_buf_reg  <= 8'd0;
            angle_reg     <= 18'd0;
            linear_reg    <= 18'd0;
            prev_cap_reg  <= 16'd0;
            period_reg    <= 16'd0;
            dir_reg       <= DIR_NONE;
            done_reg      <= 1'b0;
            den_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prev_pins_reg <= pins;
                        last_dir_reg  <= dir;
                        run_reg       <= step_done ? 8'd0 : run_next;
                        angle_reg     <= angle_next;
                        linear_reg    <= linear_next;
                        prev_cap_reg  <= in_item.capture_time;
                        period_reg    <= in_item.capture_time - prev_cap_reg;
                        dir_reg       <= dir;
                        done_reg      <= step_done;
                        if (step_done)
                        begin
                            if (dir == DIR_CW)
                            begin
                                step_cnt_reg <= step_cnt_reg + 1'b1;
                                step_buf_reg <= {1'b0, sbv_reg};
                            end
                            else
                            begin
                                step_cnt_reg <= step_cnt_reg - 1'b1;
                                step_buf_reg <= 8'd0 - {1'b0, sbv_reg};
                            end
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    den_reg   <= {16'd0, period_reg} * {16'd0, ppr_reg};
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= out_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

[sv/qet_checker.sv]
`include "assert_macros.svh"

module qet_checker
    import qet_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_W-1:0]       m_axis_tdata
);

    out_item_t res;
    logic      res_zero_period;
    logic      res_at_max;
    logic      res_moved;
    logic      res_stalled;

    assign res             = out_item_t'(m_axis_tdata);
    assign res_zero_period = m_axis_tvalid && res.edge_period == 16'd0;
    assign res_at_max      = res.speed_overflow && res.speed_hz_q8 == SPEED_MAX;
    assign res_moved       = res.direction == DIR_CW || res.direction == DIR_CCW;
    assign res_stalled     = m_axis_tvalid && !m_axis_tready;

    // one item in flight: input side closes right after an accept
    `QET_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // a zero period always reports speed overflow
    `QET_ASSERT(a_zero_period_ovf, res_zero_period |-> res_at_max)

    // a step only completes on a move
    `QET_ASSERT(a_step_needs_move, m_axis_tvalid && res.step_done |-> res_moved)

    // stalled result holds
    `QET_ASSERT(a_out_hold, res_stalled |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind quadrature_encoder_tracker qet_checker u_qet_checker (.*);
